[sv/lztsd_pkg.sv]
// shared types, constants and the match tag table for the token decompressor
`default_nettype none

package lztsd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = ADDR_W + 1;
  localparam int LEN_W        = 6;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OFS   = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  typedef enum logic [1:0] {
    EM_LIT,
    EM_COPY,
    EM_ERR,
    EM_TRUNC
  } emit_kind_t;

  typedef struct packed {
    logic       load_in;
    logic       clear_fill;
    logic       save_code;
    logic       start_copy;
    logic       copy_read;
    logic       emit;
    emit_kind_t emit_kind;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       start;
    logic       last_in;
    logic       ofs_bad;
    logic       len_zero;
    logic       copy_last;
    logic       out_free;
  } dp_status_t;

  // entry: copy length in bits 7:0, high offset nibble in bits 11:8
  function automatic logic [255:0][15:0] build_tag_table();
    logic [255:0][15:0] tbl;
    logic [28:0][15:0]  present;
    longint unsigned    step;
    longint unsigned    v;
    int                 nxt;
    tbl     = '0;
    present = '0;
    step    = 64'd65536;
    nxt     = 32;
    for (int col = 0; col < 16; col++) begin
      v    = 64'd65535;
      step = (step * 64'd67537) >> 16;
      while (v < (64'd29 << 16)) begin
        present[int'(v >> 16)][col] = 1'b1;
        v = (v * step) >> 16;
      end
    end
    for (int len = 0; len < 29; len++) begin
      for (int col = 0; col < 16; col++) begin
        if (present[len][col] && nxt < 256) begin
          tbl[nxt] = 16'((len + 4) | (col << 8));
          nxt++;
        end
      end
    end
    return tbl;
  endfunction

  localparam logic [255:0][15:0] TAG_TABLE = build_tag_table();

endpackage

`default_nettype wire

[sv/lztsd_dp.sv]
// datapath: input latch, history window, copy pointers and output register
`default_nettype none

module lztsd_dp import lztsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       block_start,
  input  wire logic       block_end,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic [1:0]      error_code
);

  logic [7:0]        byte_r;
  logic              start_r;
  logic              end_r;
  logic [7:0]        pending_code;
  logic [ADDR_W-1:0] wp;
  logic [FILL_W-1:0] filled;
  logic [ADDR_W-1:0] src;
  logic [LEN_W-1:0]  copy_left;
  logic [7:0]        rd_data;
  logic [7:0]        history [WINDOW_DEPTH];

  logic [11:0]       info;
  logic [ADDR_W-1:0] ofs;
  logic              push;
  logic [7:0]        push_data;

  assign info = TAG_TABLE[pending_code][11:0];
  assign ofs  = ADDR_W'({info[11:8], byte_r});
  assign push = cmd.emit && (cmd.emit_kind inside {EM_LIT, EM_COPY});
  assign push_data = (cmd.emit_kind == EM_LIT) ? byte_r : rd_data;

  always_comb begin
    status.byte_val  = byte_r;
    status.start     = start_r;
    status.last_in   = end_r;
    status.ofs_bad   = (ofs == '0) || ({1'b0, ofs} > filled);
    status.len_zero  = (info[7:0] == 8'd0);
    status.copy_last = (copy_left == LEN_W'(1));
    status.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      history[wp] <= push_data;
    end
    if (cmd.copy_read) begin
      rd_data <= history[src];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r  <= in_byte;
      start_r <= block_start;
      end_r   <= block_end;
    end
    if (cmd.start_copy) begin
      copy_left <= info[LEN_W-1:0];
      src       <= wp - ofs;
    end else if (push && cmd.emit_kind == EM_COPY) begin
      copy_left <= copy_left - LEN_W'(1);
      src       <= src + ADDR_W'(1);
    end
    if (cmd.emit) begin
      run_last <= cmd.emit_last;
      case (cmd.emit_kind)
        EM_LIT: begin
          out_byte   <= byte_r;
          error_code <= ERR_NONE;
        end
        EM_COPY: begin
          out_byte   <= rd_data;
          error_code <= ERR_NONE;
        end
        EM_ERR: begin
          out_byte   <= 8'd0;
          error_code <= ERR_OFS;
        end
        default: begin
          out_byte   <= 8'd0;
          error_code <= ERR_TRUNC;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      filled       <= '0;
      pending_code <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.save_code) begin
        pending_code <= byte_r;
      end
      if (cmd.clear_fill) begin
        filled <= '0;
      end else if (push && filled != FILL_W'(WINDOW_DEPTH)) begin
        filled <= filled + FILL_W'(1);
      end
      if (push) begin
        wp <= wp + ADDR_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/lztsd_ctrl.sv]
// controller: token phase tracking and item sequencing
`default_nettype none

module lztsd_ctrl import lztsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_EMIT_LIT   = 3'd2;
  localparam logic [2:0] S_EMIT_ERR   = 3'd3;
  localparam logic [2:0] S_CPY_RD     = 3'd4;
  localparam logic [2:0] S_CPY_WR     = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;
  localparam logic [2:0] S_EMIT_TRUNC = 3'd7;

  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LIT = 2'd1;
  localparam logic [1:0] PH_OFS = 2'd2;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [LEN_W-1:0] lit_left;
  logic [LEN_W-1:0] lit_left_next;
  logic [LEN_W-1:0] lit_dec;
  logic [1:0]       eff_phase;
  logic             trunc_due;

  assign in_stall  = (state != S_IDLE);
  assign trunc_due = status.last_in && (phase != PH_TAG);
  assign eff_phase = status.start ? PH_TAG : phase;
  assign lit_dec   = (lit_left != '0) ? lit_left - LEN_W'(1) : lit_left;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    phase_next    = phase;
    lit_left_next = lit_left;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.start) begin
          cmd.clear_fill = 1'b1;
          lit_left_next  = '0;
        end
        case (eff_phase)
          PH_LIT: begin
            lit_left_next = lit_dec;
            phase_next    = (lit_dec == '0) ? PH_TAG : PH_LIT;
            state_next    = S_EMIT_LIT;
          end
          PH_OFS: begin
            phase_next = PH_TAG;
            if (status.ofs_bad) begin
              state_next = S_EMIT_ERR;
            end else if (status.len_zero) begin
              state_next = S_FINISH;
            end else begin
              cmd.start_copy = 1'b1;
              state_next     = S_CPY_RD;
            end
          end
          default: begin
            if (status.byte_val[7:5] == 3'd0) begin
              lit_left_next = LEN_W'(status.byte_val[4:0]) + LEN_W'(1);
              phase_next    = PH_LIT;
            end else begin
              cmd.save_code = 1'b1;
              phase_next    = PH_OFS;
            end
            state_next = S_FINISH;
          end
        endcase
      end
      S_EMIT_LIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_LIT;
          cmd.emit_last = !trunc_due;
          state_next    = S_FINISH;
        end
      end
      S_EMIT_ERR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_ERR;
          cmd.emit_last = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_CPY_RD: begin
        cmd.copy_read = 1'b1;
        state_next    = S_CPY_WR;
      end
      S_CPY_WR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_COPY;
          cmd.emit_last = status.copy_last && !trunc_due;
          state_next    = status.copy_last ? S_FINISH : S_CPY_RD;
        end
      end
      S_FINISH: begin
        state_next = trunc_due ? S_EMIT_TRUNC : S_IDLE;
      end
      S_EMIT_TRUNC: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_TRUNC;
          cmd.emit_last = 1'b1;
          phase_next    = PH_TAG;
          lit_left_next = '0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_TAG;
      lit_left <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      lit_left <= lit_left_next;
    end
  end

endmodule

`default_nettype wire

[sv/lz_token_stream_decompressor_top.sv]
// top level of the byte-serial lz token decompressor
//
// input channel: in_valid/in_stall with in_byte, block_start, block_end.
// one compressed byte per item; block_start opens a new block and empties
// the history fill, block_end marks the last compressed byte of a block.
// output channel: out_valid/out_stall with out_byte, run_last, error_code.
// each input item causes zero or more result items; run_last flags the last.
// in_stall is high from the cycle after an item is accepted until the
// controller is back in idle, so items are taken one at a time.
// a tag byte passes decode and finish; a literal or error also passes its emit
// state; a match loops read and write states: each copied byte needs a
// registered read of the 4096-byte history ram followed by its write-back;
// a truncation result is emitted from its own state after finish. a literal
// or error is emitted straight after decode. a held output register stalls every emit.
// reset (synchronous, active high) empties the output register and the
// decoder state; history contents need no clearing and no pass is run.
`default_nettype none

module lz_token_stream_decompressor_top import lztsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       block_start,
  input  wire logic       block_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic [1:0]      error_code
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lztsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lztsd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .block_start (block_start),
    .block_end   (block_end),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .error_code  (error_code)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after accept");

  a_error_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> out_byte == 8'd0)
    else $error("error item with nonzero byte");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> run_last)
    else $error("error item not flagged last");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[dv/tb_lz_token_stream_decompressor_top.sv]
// testbench for the lz token stream decompressor: directed table then predicted random streams
module tb_lz_token_stream_decompressor_top import lztsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] MATCH_TAG_FIRST = 8'd32;
  localparam int         MAX_COPY        = 32;
  localparam logic [2:0] PRED            = 3'd7;
  localparam logic [7:0] NO_ERRS         = {4{ERR_NONE}};
  localparam int         NUM_RANDOM      = 204;

  typedef enum logic [1:0] {
    DEC_TAG,
    DEC_LIT,
    DEC_OFS
  } dec_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } result_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            bstart;
    logic            bend;
    logic [2:0]      n_out;
    logic [3:0][7:0] xb;
    logic [3:0][1:0] xe;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       block_start;
  logic       block_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic [1:0] error_code;

  logic [7:0]        hist_mem [WINDOW_DEPTH];
  logic [ADDR_W-1:0] wr_pos;
  int                fill_cnt;
  dec_phase_t        dec_phase;
  int                lit_left;
  logic [7:0]        held_tag;
  logic [5:0]        match_len [256];
  logic [3:0]        match_col [256];

  result_t   step_out[$];
  result_t   expected_q[$];
  stim_row_t dir_rows [26];
  int        err_cnt = 0;
  bit        hold_req = 1'b0;
  int        cyc = 0;

  lz_token_stream_decompressor_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .block_start(block_start),
    .block_end  (block_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .error_code (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit quiet_now();
    return cyc[9:8] == 2'd0;
  endfunction

  function automatic void init_match_table();
    logic [15:0][28:0] seen;
    longint unsigned   ratio;
    longint unsigned   acc;
    int                slot;
    seen  = '0;
    ratio = 65536;
    slot  = MATCH_TAG_FIRST;
    for (int t = 0; t < 256; t++) begin
      match_len[t] = '0;
      match_col[t] = '0;
    end
    for (int c = 0; c < 16; c++) begin
      ratio = (ratio * 67537) >> 16;
      for (acc = 65535; acc < (29 << 16); acc = (acc * ratio) >> 16) begin
        seen[c][acc >> 16] = 1'b1;
      end
    end
    for (int l = 0; l < 29; l++) begin
      for (int c = 0; c < 16; c++) begin
        if (seen[c][l] && slot < 256) begin
          match_len[slot] = 6'(l + 4);
          match_col[slot] = 4'(c);
          slot++;
        end
      end
    end
  endfunction

  function automatic void reset_decoder();
    wr_pos    = '0;
    fill_cnt  = 0;
    dec_phase = DEC_TAG;
    lit_left  = 0;
    held_tag  = '0;
  endfunction

  function automatic void store_hist(logic [7:0] v);
    hist_mem[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
    if (fill_cnt < WINDOW_DEPTH) fill_cnt++;
  endfunction

  function automatic void add_result(logic [7:0] v, logic [1:0] code);
    result_t r;
    r.data = v;
    r.last = 1'b0;
    r.err  = code;
    step_out.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic s, logic e);
    int         ofs;
    logic [7:0] v;
    result_t    r;
    step_out.delete();
    if (s) begin
      fill_cnt  = 0;
      dec_phase = DEC_TAG;
      lit_left  = 0;
    end
    case (dec_phase)
      DEC_LIT: begin
        add_result(b, ERR_NONE);
        store_hist(b);
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) dec_phase = DEC_TAG;
      end
      DEC_OFS: begin
        ofs = {match_col[held_tag], b};
        if (ofs == 0 || ofs > fill_cnt) begin
          add_result(8'h00, ERR_OFS);
        end else begin
          for (int i = 0; i < match_len[held_tag] && i < MAX_COPY; i++) begin
            v = hist_mem[(int'(wr_pos) + WINDOW_DEPTH - ofs) % WINDOW_DEPTH];
            add_result(v, ERR_NONE);
            store_hist(v);
          end
        end
        dec_phase = DEC_TAG;
      end
      default: begin
        if (b < MATCH_TAG_FIRST) begin
          lit_left  = b + 1;
          dec_phase = DEC_LIT;
        end else begin
          held_tag  = b;
          dec_phase = DEC_OFS;
        end
      end
    endcase
    if (e && dec_phase != DEC_TAG) begin
      add_result(8'h00, ERR_TRUNC);
      dec_phase = DEC_TAG;
      lit_left  = 0;
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  function automatic stim_row_t row(logic [7:0] b, logic s, logic e, logic [2:0] n,
                                    logic [31:0] xb, logic [7:0] xe);
    stim_row_t r;
    r.data   = b;
    r.bstart = s;
    r.bend   = e;
    r.n_out  = n;
    r.xb     = xb;
    r.xe     = xe;
    return r;
  endfunction

  function automatic void load_rows();
    dir_rows[0]  = row(8'h00, 1'b1, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[1]  = row(8'hFF, 1'b0, 1'b0, 3'd1, 32'h000000FF, NO_ERRS);
    dir_rows[2]  = row(8'h01, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[3]  = row(8'h00, 1'b0, 1'b0, 3'd1, 32'h00000000, NO_ERRS);
    dir_rows[4]  = row(8'hAA, 1'b0, 1'b0, 3'd1, 32'h000000AA, NO_ERRS);
    // shortest match, offset one: byte repeat
    dir_rows[5]  = row(8'h20, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[6]  = row(8'h01, 1'b0, 1'b0, 3'd4, 32'hAAAAAAAA, NO_ERRS);
    // zero offset
    dir_rows[7]  = row(8'h20, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[8]  = row(8'h00, 1'b0, 1'b0, 3'd1, 32'h0, {6'd0, ERR_OFS});
    // largest offset
    dir_rows[9]  = row(8'h2F, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[10] = row(8'hFF, 1'b0, 1'b0, 3'd1, 32'h0, {6'd0, ERR_OFS});
    // offset one beyond the fill
    dir_rows[11] = row(8'h20, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[12] = row(8'h08, 1'b0, 1'b0, 3'd1, 32'h0, {6'd0, ERR_OFS});
    // offset equal to the fill
    dir_rows[13] = row(8'h20, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[14] = row(8'h07, 1'b0, 1'b0, 3'd4, 32'hAAAA00FF, NO_ERRS);
    // longest literal run cut by block end
    dir_rows[15] = row(8'h1F, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[16] = row(8'h5A, 1'b0, 1'b0, 3'd1, 32'h0000005A, NO_ERRS);
    dir_rows[17] = row(8'h3C, 1'b0, 1'b1, 3'd2, 32'h0000003C, {4'd0, ERR_TRUNC, ERR_NONE});
    // match tag cut by block end
    dir_rows[18] = row(8'hC0, 1'b0, 1'b1, 3'd1, 32'h0, {6'd0, ERR_TRUNC});
    // block start drops a partial run
    dir_rows[19] = row(8'h1F, 1'b1, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[20] = row(8'h00, 1'b1, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[21] = row(8'h81, 1'b0, 1'b0, 3'd1, 32'h00000081, NO_ERRS);
    dir_rows[22] = row(8'h20, 1'b0, 1'b0, 3'd0, 32'h0, NO_ERRS);
    dir_rows[23] = row(8'h01, 1'b0, 1'b0, 3'd4, 32'h81818181, NO_ERRS);
    dir_rows[24] = row(8'hFF, 1'b0, 1'b0, PRED, 32'h0, NO_ERRS);
    dir_rows[25] = row(8'h03, 1'b0, 1'b0, PRED, 32'h0, NO_ERRS);
  endfunction

  task automatic pick_random(output logic [7:0] b, output logic s, output logic e);
    int unsigned roll;
    int          eff_fill;
    int          base;
    int          lo;
    int          hi;
    s        = ($urandom_range(0, 39) == 0);
    e        = ($urandom_range(0, 29) == 0);
    roll     = $urandom_range(0, 99);
    eff_fill = s ? 0 : fill_cnt;
    if (s || dec_phase == DEC_TAG) begin
      if (roll < 6) begin
        b = 8'($urandom);
      end else if (roll < 45 || eff_fill == 0) begin
        b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31))
                                        : 8'($urandom_range(0, 5));
      end else begin
        b = 8'($urandom_range(MATCH_TAG_FIRST, 255));
        for (int t = 0; t < 8 && match_col[b] * 256 >= eff_fill; t++) begin
          b = 8'($urandom_range(MATCH_TAG_FIRST, 255));
        end
        if (match_col[b] * 256 >= eff_fill) b = MATCH_TAG_FIRST;
      end
    end else if (dec_phase == DEC_OFS) begin
      base = match_col[held_tag] * 256;
      if (roll < 88 && base < fill_cnt) begin
        lo = (base == 0) ? 1 : 0;
        hi = fill_cnt - base;
        if (hi > 255) hi = 255;
        b = 8'($urandom_range(lo, hi));
      end else begin
        b = 8'($urandom);
      end
    end else begin
      b = 8'($urandom);
    end
  endtask

  task automatic offer_item(stim_row_t r);
    result_t res;
    in_valid    <= 1'b1;
    in_byte     <= r.data;
    block_start <= r.bstart;
    block_end   <= r.bend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(r.data, r.bstart, r.bend);
    if (r.n_out == PRED) begin
      foreach (step_out[k]) expected_q.push_back(step_out[k]);
    end else begin
      for (int k = 0; k < r.n_out; k++) begin
        res.data = r.xb[k];
        res.err  = r.xe[k];
        res.last = (k == r.n_out - 1);
        expected_q.push_back(res);
      end
    end
  endtask

  task automatic idle_gap();
    int unsigned g;
    g = 0;
    if (!quiet_now() && $urandom_range(0, 1) == 0) begin
      g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin : rx_side
    int unsigned hold_cnt;
    bit          held_done;
    result_t     want;
    hold_cnt  = 0;
    held_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: out_byte %02h run_last %0b error_code %0d",
                 out_byte, run_last, error_code);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_byte);
            err_cnt++;
          end
          if (run_last !== want.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", want.last, run_last);
            err_cnt++;
          end
          if (error_code !== want.err) begin
            $error("error_code mismatch: expected %0d, actual %0d", want.err, error_code);
            err_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (hold_req && !held_done) begin
        hold_cnt  = 200;
        held_done = 1'b1;
      end else if (!quiet_now() && $urandom_range(0, 2) == 0) begin
        hold_cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
      end
      out_stall <= (hold_cnt > 0);
    end
  end

  initial begin : tx_side
    logic [7:0] b;
    logic       s;
    logic       e;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_byte     <= 8'h00;
    block_start <= 1'b0;
    block_end   <= 1'b0;
    init_match_table();
    reset_decoder();
    load_rows();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i]);
      idle_gap();
    end
    // drain, then hold the output off while the sender keeps offering
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    hold_req = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick_random(b, s, e);
      offer_item(row(b, s, e, PRED, 32'h0, NO_ERRS));
      idle_gap();
    end
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && expected_q.size() != 0; w++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected result items never arrived", expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
